// ===== rtl/pmb_pkg.sv =====
// ----------------------------------------------------------------------------
// pmb_pkg: shared constants and tables for the momentum-direction block
// Fixed-point constants, CORDIC angle table and stage count limits.
// ----------------------------------------------------------------------------
package pmb_pkg;

  localparam int CordicStagesDefault = 14;
  localparam int TabLen = 32;

  localparam logic signed [16:0] Pi13 = 17'sd25736;
  localparam logic signed [17:0] TwoPi13 = 18'sd51472;
  localparam logic signed [35:0] Pi30 = 36'sd3373259426;
  localparam logic signed [35:0] HalfPi30 = 36'sd1686629713;
  localparam logic signed [35:0] One30 = 36'sd1073741824;
  localparam logic signed [35:0] Gain30 = 36'sh026DD3B6A;

  // floor(atan(2^-i) * 2^30)
  function automatic logic signed [35:0] atan_tab(input int i);
    logic [31:0] v;
    begin
      case (i)
        0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
        3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
        6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
        9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
        12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
        15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
        18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
        21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
        24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
        27: v = 32'h00000007; 28: v = 32'h00000003; 29: v = 32'h00000001;
        default: v = 32'h0;
      endcase
      atan_tab = $signed({4'b0, v});
    end
  endfunction

endpackage

// ===== rtl/pmb_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// pmb_cordic_stage: one registered CORDIC micro-rotation
// Rotation mode steers on sign of z, vectoring mode on sign of y.
// ----------------------------------------------------------------------------
module pmb_cordic_stage #(
  parameter int Shift = 0,
  parameter bit Vectoring = 1'b0,
  parameter int SideW = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [35:0]      in_x,
  input  logic signed [35:0]      in_y,
  input  logic signed [35:0]      in_z,
  input  logic [SideW-1:0]        in_side,
  output logic                    out_valid,
  output logic signed [35:0]      out_x,
  output logic signed [35:0]      out_y,
  output logic signed [35:0]      out_z,
  output logic [SideW-1:0]        out_side
);

  logic signed [35:0] dx, dy, ang;
  logic               up;

  always_comb begin
    dx  = in_y >>> Shift;
    dy  = in_x >>> Shift;
    ang = pmb_pkg::atan_tab(Shift);
    up  = Vectoring ? (in_y > 0) : (in_z >= 0);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    out_side <= in_side;
    if (up) begin
      if (Vectoring) begin
        out_x <= in_x + dx; out_y <= in_y - dy; out_z <= in_z + ang;
      end else begin
        out_x <= in_x - dx; out_y <= in_y + dy; out_z <= in_z - ang;
      end
    end else begin
      if (Vectoring) begin
        out_x <= in_x - dx; out_y <= in_y + dy; out_z <= in_z - ang;
      end else begin
        out_x <= in_x + dx; out_y <= in_y - dy; out_z <= in_z + ang;
      end
    end
  end

endmodule

// ===== rtl/phi_momentum_from_bending_top.sv =====
// ----------------------------------------------------------------------------
// phi_momentum_from_bending_top: momentum direction angle from bending
// Rotation CORDIC for sin/cos of the bend, vectoring CORDIC for the
// correction angle, fully pipelined.
// ----------------------------------------------------------------------------
// One transaction enters per clock: busy is tied low, so start is always
// taken. The result appears on phi_momentum/invalid with done high after
// the input, rotation CORDIC, setup, vectoring CORDIC, angle-fix and output
// registers, each CORDIC pipeline having one register per micro-rotation
// and N of them, N being CORDIC_STAGES clipped to 32. The receiver cannot
// stall; results must be captured in the cycle done is high.
module phi_momentum_from_bending_top #(
  parameter int CORDIC_STAGES = pmb_pkg::CordicStagesDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic signed [15:0] angle_a,
  input  logic signed [15:0] angle_b,
  input  logic signed [15:0] geom_x,
  output logic               done,
  output logic signed [15:0] phi_momentum,
  output logic               invalid
);

  // Stages beyond the table carry zero angles; more than 32 are clipped.
  localparam int N = (CORDIC_STAGES > pmb_pkg::TabLen) ? pmb_pkg::TabLen : CORDIC_STAGES;
  // side band: b(16) x(16) inv(1) neg(1)
  localparam int SideW = 34;

  assign busy = 1'b0;

  // ---- stage 0: range check, bend, fold ----
  logic               s0_v, s0_inv, s0_neg;
  logic signed [15:0] s0_b, s0_x;
  logic signed [35:0] s0_z;
  logic signed [17:0] bend;
  logic signed [35:0] z_raw;
  logic               bad;

  always_comb begin
    bad = (18'(angle_a) > 18'(pmb_pkg::Pi13)) || (18'(angle_a) < -18'(pmb_pkg::Pi13)) ||
          (18'(angle_b) > 18'(pmb_pkg::Pi13)) || (18'(angle_b) < -18'(pmb_pkg::Pi13));
    bend = mode ? (18'(angle_a) - 18'(angle_b)) : 18'(angle_a);
    // only the derived bend of mode 1 is wrapped
    if (mode) begin
      if (bend > 18'(pmb_pkg::Pi13)) bend = bend - pmb_pkg::TwoPi13;
      else if (bend <= -18'(pmb_pkg::Pi13)) bend = bend + pmb_pkg::TwoPi13;
    end
    z_raw = 36'(bend) <<< 17;
  end

  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else s0_v <= start;
  end

  always_ff @(posedge clk) begin
    s0_inv <= bad;
    s0_b   <= angle_b;
    s0_x   <= geom_x;
    if (z_raw > pmb_pkg::HalfPi30) begin
      s0_z <= z_raw - pmb_pkg::Pi30; s0_neg <= 1'b1;
    end else if (z_raw < -pmb_pkg::HalfPi30) begin
      s0_z <= z_raw + pmb_pkg::Pi30; s0_neg <= 1'b1;
    end else begin
      s0_z <= z_raw; s0_neg <= 1'b0;
    end
  end

  // ---- rotation pipeline ----
  logic               rv [0:N];
  logic signed [35:0] rx [0:N];
  logic signed [35:0] ry [0:N];
  logic signed [35:0] rz [0:N];
  logic [SideW-1:0]   rs [0:N];

  assign rv[0] = s0_v;
  assign rx[0] = pmb_pkg::Gain30;
  assign ry[0] = '0;
  assign rz[0] = s0_z;
  assign rs[0] = {s0_b, s0_x, s0_inv, s0_neg};

  for (genvar i = 0; i < N; i++) begin : g_rot
    pmb_cordic_stage #(.Shift(i), .Vectoring(1'b0), .SideW(SideW)) u_stage (
      .clk, .rst,
      .in_valid(rv[i]), .in_x(rx[i]), .in_y(ry[i]), .in_z(rz[i]), .in_side(rs[i]),
      .out_valid(rv[i+1]), .out_x(rx[i+1]), .out_y(ry[i+1]), .out_z(rz[i+1]),
      .out_side(rs[i+1])
    );
  end

  // ---- stage 1: y = 1 - cos - X, vectoring setup ----
  logic               s1_v, s1_zero;
  logic signed [35:0] s1_x, s1_y;
  logic [SideW-1:0]   s1_side;
  logic signed [35:0] cosv, sinv, yv;

  always_comb begin
    cosv = rs[N][0] ? -rx[N] : rx[N];
    sinv = rs[N][0] ? -ry[N] : ry[N];
    yv   = pmb_pkg::One30 - cosv - (36'($signed(rs[N][17:2])) <<< 18);
  end

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else s1_v <= rv[N];
  end

  always_ff @(posedge clk) begin
    s1_side <= rs[N];
    s1_zero <= (yv == 0);
    if (yv < 0) begin
      s1_x <= -yv; s1_y <= -sinv;
    end else begin
      s1_x <= yv; s1_y <= sinv;
    end
  end

  // ---- vectoring pipeline ----
  logic               vv [0:N];
  logic signed [35:0] vx [0:N];
  logic signed [35:0] vy [0:N];
  logic signed [35:0] vz [0:N];
  logic [SideW:0]     vs [0:N];

  assign vv[0] = s1_v;
  assign vx[0] = s1_x;
  assign vy[0] = s1_y;
  assign vz[0] = '0;
  assign vs[0] = {s1_side, s1_zero};

  for (genvar i = 0; i < N; i++) begin : g_vec
    pmb_cordic_stage #(.Shift(i), .Vectoring(1'b1), .SideW(SideW + 1)) u_stage (
      .clk, .rst,
      .in_valid(vv[i]), .in_x(vx[i]), .in_y(vy[i]), .in_z(vz[i]), .in_side(vs[i]),
      .out_valid(vv[i+1]), .out_x(vx[i+1]), .out_y(vy[i+1]), .out_z(vz[i+1]),
      .out_side(vs[i+1])
    );
  end

  // ---- stage 2: correction rounding ----
  logic               s2_v, s2_inv;
  logic signed [15:0] s2_b;
  logic signed [18:0] s2_d;
  logic signed [35:0] diff30, rnd;

  always_comb begin
    diff30 = vs[N][0] ? pmb_pkg::HalfPi30 : vz[N];
    rnd    = (diff30 + 36'sd65536) >>> 17;
  end

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else s2_v <= vv[N];
  end

  always_ff @(posedge clk) begin
    s2_b   <= $signed(vs[N][SideW:SideW-15]);
    s2_inv <= vs[N][2];
    s2_d   <= rnd[18:0];
  end

  // ---- stage 3: subtract and wrap ----
  logic signed [19:0] ph;

  always_comb begin
    ph = 20'(s2_b) - 20'(s2_d);
    if (ph > 20'(pmb_pkg::Pi13)) ph = ph - 20'(pmb_pkg::TwoPi13);
    else if (ph <= -20'(pmb_pkg::Pi13)) ph = ph + 20'(pmb_pkg::TwoPi13);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= s2_v;
  end

  always_ff @(posedge clk) begin
    invalid      <= s2_inv;
    phi_momentum <= s2_inv ? 16'sd0 : ph[15:0];
  end

  // ---- assertions ----
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s1_v |-> ##(N+2) done) else $error("result strobe lost in pipeline");
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    (done && invalid) |-> (phi_momentum == 16'sd0)) else $error("invalid result not zero");
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (phi_momentum <= 16'sd25736 && phi_momentum > -16'sd25736))
    else $error("result out of range");

endmodule

// ===== tb/sv/tb_phi_momentum_from_bending_top.sv =====
// ----------------------------------------------------------------------------
// tb_phi_momentum_from_bending_top: momentum direction angle testbench
// Drives directed and random angle/geometry transactions, predicts phiM
// with a bit-exact CORDIC model and checks every done strobe in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_phi_momentum_from_bending_top;

  localparam int Stages = pmb_pkg::CordicStagesDefault;
  localparam int Latency = Stages * 2 + 4;
  localparam int NumRandom = 630;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               mode = 1'b0;
  logic signed [15:0] angle_a = '0;
  logic signed [15:0] angle_b = '0;
  logic signed [15:0] geom_x = '0;
  logic               done;
  logic signed [15:0] phi_momentum;
  logic               invalid;

  typedef struct packed {
    logic signed [15:0] phi;
    logic               inv;
  } phim_t;

  // Directed row: inputs, plus an expected result where obvious
  typedef struct {
    logic               md;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] x;
    bit                 has_exp;
    phim_t              exp_res;
  } stim_row_t;

  phim_t phim_queue[$];
  int    mismatches = 0;
  int    n_results = 0;
  int    n_invalid = 0;
  int    n_sent = 0;

  phi_momentum_from_bending_top #(.CORDIC_STAGES(Stages)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .angle_a(angle_a), .angle_b(angle_b), .geom_x(geom_x),
    .done(done), .phi_momentum(phi_momentum), .invalid(invalid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint wrap_pi(longint v);
    if (v > pmb_pkg::Pi13) v -= pmb_pkg::TwoPi13;
    else if (v <= -pmb_pkg::Pi13) v += pmb_pkg::TwoPi13;
    return v;
  endfunction

  function automatic int n_stages();
    return (Stages > pmb_pkg::TabLen) ? pmb_pkg::TabLen : Stages;
  endfunction

  // Vectoring CORDIC angle of (vx, vy), vx >= 0, in 2^-30 rad
  function automatic longint vector_angle(longint vx, longint vy);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < n_stages(); i++) begin
      dx = floor_shr(vy, i);
      dy = floor_shr(vx, i);
      if (vy > 0) begin
        vx += dx; vy -= dy; z += pmb_pkg::atan_tab(i);
      end else begin
        vx -= dx; vy += dy; z -= pmb_pkg::atan_tab(i);
      end
    end
    return z;
  endfunction

  function automatic phim_t predict_phim(logic md, logic signed [15:0] a,
                                         logic signed [15:0] b,
                                         logic signed [15:0] xf);
    phim_t  r;
    longint la, lb, bend, z, cx, sy, dx, dy, yv, corr30, corr13;
    bit     fold;
    la = a;
    lb = b;
    r.phi = '0;
    r.inv = 1'b0;
    if (la > pmb_pkg::Pi13 || la < -pmb_pkg::Pi13 ||
        lb > pmb_pkg::Pi13 || lb < -pmb_pkg::Pi13) begin
      r.inv = 1'b1;
      return r;
    end
    bend = md ? wrap_pi(la - lb) : la;
    // rotation CORDIC, folded by pi beyond a quarter turn
    z = bend * 131072;
    cx = pmb_pkg::Gain30;
    sy = 0;
    fold = 0;
    if (z > pmb_pkg::HalfPi30) begin
      z -= pmb_pkg::Pi30; fold = 1;
    end else if (z < -pmb_pkg::HalfPi30) begin
      z += pmb_pkg::Pi30; fold = 1;
    end
    for (int i = 0; i < n_stages(); i++) begin
      dx = floor_shr(sy, i);
      dy = floor_shr(cx, i);
      if (z >= 0) begin
        cx -= dx; sy += dy; z -= pmb_pkg::atan_tab(i);
      end else begin
        cx += dx; sy -= dy; z += pmb_pkg::atan_tab(i);
      end
    end
    if (fold) begin
      cx = -cx; sy = -sy;
    end
    yv = pmb_pkg::One30 - cx - longint'(xf) * 262144;
    if (yv == 0) corr30 = pmb_pkg::HalfPi30;
    else if (yv > 0) corr30 = vector_angle(yv, sy);
    else corr30 = vector_angle(-yv, -sy);
    corr13 = floor_shr(corr30 + 65536, 17);
    r.phi = 16'(wrap_pi(lb - corr13));
    return r;
  endfunction

  // ------------------------------------------------------------------ checker
  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR @%0t result %0d: %s got %0d expected %0d",
             $realtime, n_results, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    phim_t want;
    if (!rst && done) begin
      if (phim_queue.size() == 0) begin
        report_mismatch("unexpected done, queue depth", 1, 0);
      end else begin
        want = phim_queue.pop_front();
        if (invalid !== want.inv) report_mismatch("invalid", invalid, want.inv);
        if (phi_momentum !== want.phi)
          report_mismatch("phi_momentum", phi_momentum, want.phi);
        if (invalid === 1'b1) n_invalid++;
      end
      n_results++;
    end
  end

  // ----------------------------------------------------------------- stimulus
  bit idle_ok = 1'b1;

  // One transaction: optional random idle, then start until taken.
  // Start stays high across back-to-back transactions.
  task automatic send(logic md, logic signed [15:0] a, logic signed [15:0] b,
                      logic signed [15:0] x, bit has_exp, phim_t exp_res);
    phim_t p;
    if (idle_ok) begin
      while ($urandom_range(99) < 18) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start    <= 1'b1;
    mode     <= md;
    angle_a  <= a;
    angle_b  <= b;
    geom_x   <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = predict_phim(md, a, b, x);
    // typed-in rows guard the predictor itself
    if (has_exp && p !== exp_res) report_mismatch("predictor row", p, exp_res);
    phim_queue.push_back(p);
    n_sent++;
  endtask

  function automatic logic signed [15:0] rand_angle();
    int k;
    k = $urandom_range(99);
    if (k < 80) return 16'($signed($urandom_range(51472)) - 25736);
    if (k < 88) return 16'($urandom);            // often out of range
    return $urandom_range(1) ? 16'sd25736 : -16'sd25736;
  endfunction

  function automatic logic signed [15:0] rand_x();
    int k;
    k = $urandom_range(99);
    if (k < 60) return 16'($signed($urandom_range(16384)) - 8192); // |X| <= 2
    if (k < 70) return 16'sd4096;                    // y near -1 at bend 0
    return 16'($urandom);
  endfunction

  stim_row_t rows[$];

  function automatic stim_row_t mk(logic md, int a, int b, int x,
                                   bit he = 0, int ph = 0, bit iv = 0);
    stim_row_t r;
    r.md = md; r.a = 16'(a); r.b = 16'(b); r.x = 16'(x);
    r.has_exp = he;
    r.exp_res.phi = 16'(ph);
    r.exp_res.inv = iv;
    return r;
  endfunction

  initial begin
    phim_t none;
    none = '0;
    // angles beyond pi: invalid, phiM forced to zero
    rows.push_back(mk(0, 25737, 0, 0, 1, 0, 1));
    rows.push_back(mk(1, 0, -25737, 0, 1, 0, 1));
    rows.push_back(mk(0, 32767, 32767, 32767, 1, 0, 1));
    rows.push_back(mk(1, -32768, -32768, -32768, 1, 0, 1));
    // angle extremes at exactly +-pi
    rows.push_back(mk(0, 25736, 25736, 0));
    rows.push_back(mk(0, -25736, -25736, 0));
    rows.push_back(mk(1, 25736, -25736, 0));
    rows.push_back(mk(1, -25736, 25736, 0));
    // zero bend, X = 1: y near -1, correction near zero
    rows.push_back(mk(0, 0, 0, 4096));
    rows.push_back(mk(1, 1000, 1000, 4096));
    // negative y (large X) and positive y (negative X)
    rows.push_back(mk(0, 3000, 12000, 20000));
    rows.push_back(mk(0, -3000, -12000, -20000));
    // bend beyond a quarter turn, folded by pi
    rows.push_back(mk(0, 20000, 500, 0));
    rows.push_back(mk(0, -20000, -500, 100));
    // mode 1 wrap of the bend both ways
    rows.push_back(mk(1, 20000, -20000, 1000));
    rows.push_back(mk(1, -20000, 20000, -1000));
    // X extremes, plain angles
    rows.push_back(mk(0, 1, -1, 32767));
    rows.push_back(mk(1, -1, 1, -32768));
    rows.push_back(mk(0, 0, 0, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i])
      send(rows[i].md, rows[i].a, rows[i].b, rows[i].x,
           rows[i].has_exp, rows[i].exp_res);

    for (int i = 0; i < NumRandom; i++) begin
      // a stretch with no idle cycles at all
      idle_ok = !(i >= 200 && i < 320);
      // sender holds off until the pipeline has drained
      if (i == 400) begin
        start <= 1'b0;
        @(posedge clk);
        while (phim_queue.size() != 0) @(posedge clk);
      end
      send($urandom_range(1), rand_angle(), rand_angle(), rand_x(), 0, none);
    end
    start <= 1'b0;

    while (phim_queue.size() != 0) @(posedge clk);
    repeat (Latency + 8) @(posedge clk);

    $display("Sent %0d transactions in both modes (incl. out-of-range angles,", n_sent);
    $display("y = 0, folded bends); checked %0d results, %0d invalid.",
             n_results, n_invalid);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000;
    $display("Timeout waiting for results");
    $display("Mismatches found");
    $finish;
  end

endmodule
